@@ rtl/card_number_luhn_bin_check_macros.svh @@
// Assertion helpers for the top-level RTL; both sample on clk and idle in reset.
`ifndef CARD_NUMBER_LUHN_BIN_CHECK_MACROS_SVH
`define CARD_NUMBER_LUHN_BIN_CHECK_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CLBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Expression holds at every sampled edge.
`define CLBC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

@@ rtl/clbc_pkg.sv @@
package clbc_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  localparam logic [4:0] CountSat = 5'd20;
  localparam logic [4:0] LenMin   = 5'd13;
  localparam logic [4:0] LenMax   = 5'd19;

  // One classified byte on its way from front to back
  typedef struct packed {
    logic       is_digit;
    logic [3:0] digit;
    logic       last;
  } qent_t;

endpackage

@@ rtl/clbc_front.sv @@
module clbc_front import clbc_pkg::*; (
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_run_end,
  input  logic       q_full,
  output logic       q_push,
  output qent_t      q_wdata
);

  logic [7:0] char_off;

  assign char_off = in_char_in - 8'd48;

  assign in_stall         = q_full;
  assign q_push           = in_valid && !q_full;
  assign q_wdata.is_digit = in_char_in inside {[8'd48:8'd57]};
  assign q_wdata.digit    = char_off[3:0];
  assign q_wdata.last     = in_run_end;

endmodule

@@ rtl/clbc_fifo.sv @@
module clbc_fifo import clbc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t wdata,
  input  logic  pop,
  output qent_t rdata,
  output logic  full,
  output logic  empty
);

  qent_t            mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPtrW:0]   cnt_r, cnt_nxt;

  assign full  = cnt_r == (QPtrW+1)'(QDepth);
  assign empty = cnt_r == '0;
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ rtl/clbc_back.sv @@
module clbc_back import clbc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  qent_t      q_rdata,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_card_found,
  output logic       out_luhn_ok,
  output logic       out_brand_ok,
  output logic [4:0] out_digit_total
);

  logic [4:0]      cnt_r, cnt_nxt;
  logic [3:0]      sodd_r, sodd_nxt;
  logic [3:0]      seven_r, seven_nxt;
  logic [3:0][3:0] lead_r, lead_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            card_r, luhn_r, brand_r;
  logic [4:0]      total_r;
  logic            take_digit;
  logic [3:0]      dbl;
  logic [3:0]      sel_sum;
  logic            len_ok;
  logic            luhn_c, brand_c;

  function automatic logic [3:0] add_mod10(input logic [3:0] s, input logic [3:0] v);
    logic [4:0] t;
    t = {1'b0, s} + {1'b0, v};
    if (t >= 5'd10) begin
      t = t - 5'd10;
    end
    return t[3:0];
  endfunction

  function automatic logic [3:0] doubled(input logic [3:0] d);
    logic [4:0] t;
    t = {d, 1'b0};
    if (t > 5'd9) begin
      t = t - 5'd9;
    end
    return t[3:0];
  endfunction

  function automatic logic brand_match(input logic [3:0][3:0] ld, input logic [4:0] n);
    logic [6:0]  p2;
    logic [9:0]  p3;
    logic [13:0] p4;
    logic        hit;
    p2  = {3'b0, ld[0]} * 7'd10 + {3'b0, ld[1]};
    p3  = {3'b0, p2} * 10'd10 + {6'b0, ld[2]};
    p4  = {4'b0, p3} * 14'd10 + {10'b0, ld[3]};
    hit = 1'b0;
    if (ld[0] == 4'd4 && (n == 5'd13 || n == 5'd16 || n == 5'd19)) begin
      hit = 1'b1;
    end
    if (n == 5'd16) begin
      if (p2 >= 7'd51 && p2 <= 7'd55) hit = 1'b1;
      if (p4 >= 14'd2221 && p4 <= 14'd2720) hit = 1'b1;
      if (p4 == 14'd6011) hit = 1'b1;
      if (p3 >= 10'd644 && p3 <= 10'd649) hit = 1'b1;
      if (p2 == 7'd65) hit = 1'b1;
      if (p4 >= 14'd3528 && p4 <= 14'd3589) hit = 1'b1;
    end
    if (n == 5'd15 && (p2 == 7'd34 || p2 == 7'd37)) begin
      hit = 1'b1;
    end
    if (n == 5'd14) begin
      if (p3 >= 10'd300 && p3 <= 10'd305) hit = 1'b1;
      if (p2 == 7'd36 || p2 == 7'd38) hit = 1'b1;
    end
    if (p2 == 7'd62 && n >= 5'd16 && n <= 5'd19) begin
      hit = 1'b1;
    end
    return hit;
  endfunction

  // A run's final byte needs the result register; other bytes drain freely
  assign q_pop = !q_empty && (!q_rdata.last || !out_valid_r || !out_stall);

  assign take_digit = q_pop && q_rdata.is_digit && (cnt_r < CountSat);
  assign dbl        = doubled(q_rdata.digit);

  always_comb begin
    cnt_nxt   = cnt_r;
    sodd_nxt  = sodd_r;
    seven_nxt = seven_r;
    lead_nxt  = lead_r;
    if (take_digit) begin
      if (cnt_r < 5'd4) begin
        lead_nxt[cnt_r[1:0]] = q_rdata.digit;
      end
      if (cnt_r[0]) begin
        sodd_nxt  = add_mod10(sodd_r, dbl);
        seven_nxt = add_mod10(seven_r, q_rdata.digit);
      end else begin
        sodd_nxt  = add_mod10(sodd_r, q_rdata.digit);
        seven_nxt = add_mod10(seven_r, dbl);
      end
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // Parity of the final count picks which doubling applies
  assign sel_sum = cnt_nxt[0] ? sodd_nxt : seven_nxt;
  assign len_ok  = (cnt_nxt >= LenMin) && (cnt_nxt <= LenMax);
  assign luhn_c  = len_ok && (sel_sum == 4'd0);
  assign brand_c = len_ok && brand_match(lead_nxt, cnt_nxt);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop && q_rdata.last) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sodd_r      <= '0;
      seven_r     <= '0;
      lead_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop && q_rdata.last) begin
        // clear for the next run
        cnt_r   <= '0;
        sodd_r  <= '0;
        seven_r <= '0;
        lead_r  <= '0;
      end else begin
        cnt_r   <= cnt_nxt;
        sodd_r  <= sodd_nxt;
        seven_r <= seven_nxt;
        lead_r  <= lead_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_rdata.last) begin
      card_r  <= luhn_c && brand_c;
      luhn_r  <= luhn_c;
      brand_r <= brand_c;
      total_r <= cnt_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_card_found  = card_r;
  assign out_luhn_ok     = luhn_r;
  assign out_brand_ok    = brand_r;
  assign out_digit_total = total_r;

endmodule

@@ rtl/card_number_luhn_bin_check.sv @@
// Path: a run's final byte is written into the queue, then popped once the bytes ahead of it
//   have drained and the result register is free; its result is then registered.
// Throughput: one byte per cycle, less while in_stall or out_stall holds the flow.
// Reset: synchronous, active-low rst_n empties the queue, clears all sums, counts,
//   leading digits and the result valid; no clearing pass is needed.
`include "card_number_luhn_bin_check_macros.svh"

module card_number_luhn_bin_check import clbc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_run_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_card_found,
  output logic       out_luhn_ok,
  output logic       out_brand_ok,
  output logic [4:0] out_digit_total
);

  qent_t q_wdata;
  qent_t q_rdata;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  logic  total_legal;
  logic  flags_and;

  clbc_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char_in (in_char_in),
    .in_run_end (in_run_end),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  clbc_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  clbc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_rdata         (q_rdata),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_card_found  (out_card_found),
    .out_luhn_ok     (out_luhn_ok),
    .out_brand_ok    (out_brand_ok),
    .out_digit_total (out_digit_total)
  );

  assign total_legal = (out_digit_total >= LenMin) && (out_digit_total <= LenMax);
  assign flags_and   = out_luhn_ok && out_brand_ok;

  `CLBC_ASSERT_IMP(a_luhn_len, out_valid && out_luhn_ok, total_legal, "luhn_ok with bad length")
  `CLBC_ASSERT_IMP(a_brand_len, out_valid && out_brand_ok, total_legal, "brand_ok with bad length")
  `CLBC_ASSERT_IMP(a_total_sat, out_valid, out_digit_total <= CountSat, "digit count past saturation")
  `CLBC_ASSERT_IMP(a_card_and, out_valid, out_card_found == flags_and, "card_found not the AND of flags")

endmodule
